@@ src/pbsm_pkg.sv @@
// Shared types and constants for the playout buffer stall monitor.
// No dependencies; imported by playout_buffer_stall_monitor_core and the testbench.
`default_nettype none

package pbsm_pkg;

	localparam int NUM_FLOWS_DEF = 16;

	localparam int FLOW_W   = 4;
	localparam int SEQ_W    = 32;
	localparam int TIME_W   = 48;
	localparam int COUNT_W  = 17;
	localparam int PERIOD_W = 10;
	localparam int BUF_W    = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BUFFER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BUFFER   = 2'd2;

	localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 10'd40;
	localparam logic [BUF_W-1:0]    MIN_BUFFER_RST   = 16'd5;
	localparam logic [BUF_W-1:0]    MAX_BUFFER_RST   = 16'd50;

	localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

	localparam logic EVT_START = 1'b0;
	localparam logic EVT_STOP  = 1'b1;

	typedef struct packed {
		logic [FLOW_W-1:0] flow_id;
		logic [SEQ_W-1:0]  seq_num;
		logic [TIME_W-1:0] now_ms;
	} pkt_item_t;

	typedef struct packed {
		logic              event_kind;
		logic [FLOW_W-1:0] event_flow;
		logic [SEQ_W-1:0]  event_seq;
		logic [TIME_W-1:0] event_time;
	} evt_item_t;

	// Per-flow record kept in the state memory.
	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
		logic [TIME_W-1:0]  play_base_time;
	} flow_rec_t;

endpackage

`default_nettype wire

@@ src/playout_buffer_stall_monitor_core.sv @@
// Playout buffer stall monitor top level: sequencer, bit-serial divider, flow state.
// Depends on pbsm_pkg and pbsm_ram.
`default_nettype none

// Each packet request adds one frame to its flow's buffer count and may emit one
// start or stop event. The block handles one packet at a time: in_ready is high
// only while the sequencer is idle. A packet for a stopped flow, or for a playing
// flow whose arrival time lies behind its base time, passes S_LOAD, S_DECIDE and
// S_COMMIT before the next acceptance; any other packet for a playing flow also
// runs S_DIV, the shared restoring divider that yields one bit of the 48-bit drain
// quotient per cycle. A packet whose flow_id is not below NUM_FLOWS is dropped
// in the accept cycle. An event waits in the output register; the sequencer
// stalls before committing a new event only while the previous one is unread.
// Flow records live in a RAM with one valid flop per flow, so reset clears all
// flows at once with no sweep.

module playout_buffer_stall_monitor_core import pbsm_pkg::*; #(
	parameter int NUM_FLOWS = NUM_FLOWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire pkt_item_t             in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output evt_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IDX_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
	localparam int REC_W = $bits(flow_rec_t);
	localparam int DCNT_W = $clog2(TIME_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_DECIDE,
		S_COMMIT
	} state_t;

	state_t state_q;

	logic [PERIOD_W-1:0] frame_period_q;
	logic [BUF_W-1:0]    min_buffer_q;
	logic [BUF_W-1:0]    max_buffer_q;

	logic [NUM_FLOWS-1:0] valid_q;
	logic [NUM_FLOWS-1:0] playing_q;

	logic [IDX_W-1:0]    idx_q;
	logic [FLOW_W-1:0]   flow_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [TIME_W-1:0]   now_q;
	logic [COUNT_W-1:0]  count_q;
	logic [TIME_W-1:0]   base_q;
	logic [PERIOD_W-1:0] period_q;
	logic                play_q;
	logic                emit_q;
	logic                kind_q;

	// Divider: dq_q holds the dividend and shifts quotient bits in from the right.
	logic [TIME_W-1:0]   dq_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [DCNT_W-1:0]   dcnt_q;

	logic                in_take;
	logic                flow_ok;
	logic [IDX_W-1:0]    in_idx;
	logic                out_free;
	logic                commit_go;
	flow_rec_t           rd_rec;
	flow_rec_t           cur_rec;
	flow_rec_t           wr_rec;
	logic [REC_W-1:0]    ram_rdata;
	logic [COUNT_W-1:0]  count_inc;
	logic [TIME_W:0]     diff;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   trial_sub;
	logic [TIME_W-1:0]   quot;
	logic [TIME_W-1:0]   base_adv;

	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign flow_ok   = ({{(32-FLOW_W){1'b0}}, in_data.flow_id} < 32'(NUM_FLOWS));
	assign in_idx    = IDX_W'(in_data.flow_id);
	assign out_free  = !out_valid || out_ready;
	assign commit_go = (state_q == S_COMMIT) && (!emit_q || out_free);

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q <= FRAME_PERIOD_RST;
			min_buffer_q   <= MIN_BUFFER_RST;
			max_buffer_q   <= MAX_BUFFER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_PERIOD: frame_period_q <= cfg_wdata[PERIOD_W-1:0];
				REG_MIN_BUFFER:   min_buffer_q   <= cfg_wdata[BUF_W-1:0];
				REG_MAX_BUFFER:   max_buffer_q   <= cfg_wdata[BUF_W-1:0];
				default: ;
			endcase
		end
	end

	assign wr_rec.frame_count    = count_q;
	assign wr_rec.play_base_time = base_q;

	pbsm_ram #(
		.WIDTH (REC_W),
		.DEPTH (NUM_FLOWS)
	) u_flow_ram (
		.clk   (clk),
		.we    (commit_go),
		.waddr (idx_q),
		.wdata (wr_rec),
		.re    (in_take),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	always_comb begin
		rd_rec  = flow_rec_t'(ram_rdata);
		cur_rec = valid_q[idx_q] ? rd_rec : '0;
		count_inc = (cur_rec.frame_count == COUNT_SAT) ? COUNT_SAT
		                                               : cur_rec.frame_count + 1'b1;
		diff      = {1'b0, now_q} - {1'b0, cur_rec.play_base_time};
		trial     = {rem_q, dq_q[TIME_W-1]};
		trial_sub = trial - {1'b0, period_q};
		quot      = dq_q;
		// base + c * period equals now - remainder
		base_adv  = now_q - {{(TIME_W-PERIOD_W){1'b0}}, rem_q};
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			playing_q <= '0;
			out_valid <= 1'b0;
			emit_q    <= 1'b0;
		end else begin
			if (out_valid && out_ready && !(commit_go && emit_q)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take && flow_ok) begin
						idx_q   <= in_idx;
						flow_q  <= in_data.flow_id;
						seq_q   <= in_data.seq_num;
						now_q   <= in_data.now_ms;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					count_q  <= count_inc;
					base_q   <= cur_rec.play_base_time;
					play_q   <= playing_q[idx_q];
					period_q <= (frame_period_q == '0) ? PERIOD_W'(1) : frame_period_q;
					rem_q    <= '0;
					dcnt_q   <= DCNT_W'(TIME_W - 1);
					// time going backwards drains nothing
					if (playing_q[idx_q] && !diff[TIME_W]) begin
						dq_q    <= diff[TIME_W-1:0];
						state_q <= S_DIV;
					end else begin
						dq_q    <= '0;
						state_q <= S_DECIDE;
					end
				end
				S_DIV: begin
					if (!trial_sub[PERIOD_W]) begin
						rem_q <= trial_sub[PERIOD_W-1:0];
						dq_q  <= {dq_q[TIME_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[PERIOD_W-1:0];
						dq_q  <= {dq_q[TIME_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (play_q) begin
						if (quot != '0) begin
							base_q <= base_adv;
							if (quot >= TIME_W'(count_q)) begin
								count_q <= '0;
								play_q  <= 1'b0;
								emit_q  <= 1'b1;
								kind_q  <= EVT_STOP;
							end else begin
								count_q <= count_q - quot[COUNT_W-1:0];
								emit_q  <= 1'b0;
							end
						end else begin
							emit_q <= 1'b0;
							if (count_q > {1'b0, max_buffer_q}) begin
								count_q <= {1'b0, max_buffer_q};
							end
						end
					end else if (count_q == {1'b0, min_buffer_q}) begin
						play_q <= 1'b1;
						base_q <= now_q;
						emit_q <= 1'b1;
						kind_q <= EVT_START;
					end else begin
						emit_q <= 1'b0;
					end
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					// hold while the previous event is still unread
					if (commit_go) begin
						valid_q[idx_q]   <= 1'b1;
						playing_q[idx_q] <= play_q;
						if (emit_q) begin
							out_valid           <= 1'b1;
							out_data.event_kind <= kind_q;
							out_data.event_flow <= flow_q;
							out_data.event_seq  <= seq_q;
							out_data.event_time <= now_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_play_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(playing_q & ~valid_q) == '0)
		else $error("flow marked playing without a stored record");

	a_div_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (period_q != '0))
		else $error("divider running with zero period");

	a_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> (rem_q < period_q))
		else $error("divider remainder not below period");

	a_event_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_COMMIT) && $past(emit_q))
		else $error("event raised outside commit");

	a_idle_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after commit");

endmodule

`default_nettype wire

@@ src/pbsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Uses no package items; instantiated by playout_buffer_stall_monitor_core.
`default_nettype none

module pbsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking bench for playout_buffer_stall_monitor_core: per-flow buffer predictor,
// queued packet driver, event monitor, register phases. Depends on pbsm_pkg and the core.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
	import pbsm_pkg::*;

	localparam int FLOWS         = NUM_FLOWS_DEF;
	localparam int SETTLE_CYCLES = 100;
	localparam int STALL_LIMIT   = 4000;
	localparam int MAX_REPORTS   = 40;
	localparam int BULK_PKTS     = 40;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	pkt_item_t             in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	evt_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Predicted per-flow buffer state and register copies
	logic [COUNT_W-1:0]  buf_count    [FLOWS];
	logic [TIME_W-1:0]   base_time    [FLOWS];
	logic                flow_playing [FLOWS];
	logic [PERIOD_W-1:0] cfg_period = FRAME_PERIOD_RST;
	logic [BUF_W-1:0]    cfg_min    = MIN_BUFFER_RST;
	logic [BUF_W-1:0]    cfg_max    = MAX_BUFFER_RST;

	pkt_item_t         pkts_to_send [$];
	evt_item_t         events_due   [$];
	logic [TIME_W-1:0] flow_clock   [FLOWS];
	evt_item_t         predicted;
	evt_item_t         wanted;
	int                focus_flow     = 0;
	int                bulk_flow      = 0;
	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;
	bit                send_hold      = 1'b0;
	int                errors         = 0;
	int                quiet_cycles   = 0;

	playout_buffer_stall_monitor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance one flow by one packet; return 1 with the event when one is due.
	function automatic bit predict_event(input pkt_item_t pkt, output evt_item_t evt);
		int                fi;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] drain;
		fi = int'(pkt.flow_id);
		evt = '0;
		evt.event_flow = pkt.flow_id;
		evt.event_seq  = pkt.seq_num;
		evt.event_time = pkt.now_ms;
		if (fi >= FLOWS)
			return 1'b0;
		if (buf_count[fi] != COUNT_SAT)
			buf_count[fi] = buf_count[fi] + 1'b1;
		if (flow_playing[fi]) begin
			period = (cfg_period == '0) ? TIME_W'(1) : TIME_W'(cfg_period);
			drain = (pkt.now_ms >= base_time[fi]) ? (pkt.now_ms - base_time[fi]) / period : '0;
			if (drain != '0) begin
				base_time[fi] = base_time[fi] + drain * period;
				// compare at full width: a drain of at least the count stops the flow
				if (drain >= TIME_W'(buf_count[fi])) begin
					buf_count[fi] = '0;
					flow_playing[fi] = 1'b0;
					evt.event_kind = EVT_STOP;
					return 1'b1;
				end
				buf_count[fi] = buf_count[fi] - drain[COUNT_W-1:0];
			end else if (buf_count[fi] > COUNT_W'(cfg_max)) begin
				buf_count[fi] = COUNT_W'(cfg_max);
			end
			return 1'b0;
		end
		if (buf_count[fi] == COUNT_W'(cfg_min)) begin
			flow_playing[fi] = 1'b1;
			base_time[fi] = pkt.now_ms;
			evt.event_kind = EVT_START;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Packet driver: predict on each accepted request, then offer the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				if (predict_event(in_data, predicted))
					events_due = {events_due, predicted};
			end
			if (!in_valid || in_ready) begin
				if (pkts_to_send.size() != 0 && !send_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= pkts_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string field, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	// Event monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (events_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected event, expected none, actual %p", $time, out_data);
				end else begin
					wanted = events_due.pop_front();
					check_field("event_kind", TIME_W'(wanted.event_kind), TIME_W'(out_data.event_kind));
					check_field("event_flow", TIME_W'(wanted.event_flow), TIME_W'(out_data.event_flow));
					check_field("event_seq", TIME_W'(wanted.event_seq), TIME_W'(out_data.event_seq));
					check_field("event_time", wanted.event_time, out_data.event_time);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Hang guard: count cycles with no request moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_PERIOD: cfg_period = val[PERIOD_W-1:0];
			REG_MIN_BUFFER:   cfg_min = val;
			REG_MAX_BUFFER:   cfg_max = val;
			default:          ;
		endcase
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] period, min_frames, max_frames);
		write_reg(REG_FRAME_PERIOD, period);
		write_reg(REG_MIN_BUFFER, min_frames);
		write_reg(REG_MAX_BUFFER, max_frames);
	endtask

	// Wait until every request is through and every event is back, then let the core drain.
	task automatic wait_idle();
		@(negedge clk);
		while (pkts_to_send.size() != 0 || in_valid || events_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_pkt(input int f, input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] t);
		pkt_item_t pkt;
		pkt.flow_id = FLOW_W'(f);
		pkt.seq_num = seq;
		pkt.now_ms  = t;
		pkts_to_send = {pkts_to_send, pkt};
	endtask

	// Mostly near-real-time arrivals on a few busy flows; some bursts, gaps, rewinds, jumps.
	task automatic queue_random(input int count);
		int                f;
		int                r;
		int                p;
		logic [TIME_W-1:0] advance;
		p = (cfg_period == '0) ? 1 : int'(cfg_period);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 75)
				f = (focus_flow + int'($urandom_range(3))) % FLOWS;
			else
				f = int'($urandom_range(FLOWS - 1));
			r = int'($urandom_range(99));
			advance = '0;
			if (r < 10)
				advance = '0;
			else if (r < 65)
				advance = TIME_W'($urandom_range(2 * p));
			else if (r < 80)
				advance = TIME_W'($urandom_range(p / 2));
			else if (r < 93)
				advance = TIME_W'(p) * TIME_W'($urandom_range(40, 2));
			else if (r < 97)
				flow_clock[f] = flow_clock[f] - TIME_W'($urandom_range(4 * p));
			else
				flow_clock[f] = TIME_W'({$urandom(), $urandom()});
			flow_clock[f] = flow_clock[f] + advance;
			queue_pkt(f, $urandom(), flow_clock[f]);
		end
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] period, min_frames, max_frames,
			input int send_idle, recv_stall, count);
		wait_idle();
		set_regs(period, min_frames, max_frames);
		@(negedge clk);
		send_idle_pct  = send_idle;
		recv_stall_pct = recv_stall;
		focus_flow     = int'($urandom_range(FLOWS - 1));
		queue_random(count);
	endtask

	initial begin
		for (int i = 0; i < FLOWS; i++) begin
			buf_count[i]    = '0;
			base_time[i]    = '0;
			flow_playing[i] = 1'b0;
			flow_clock[i]   = TIME_W'({$urandom(), $urandom()});
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset register values: start on the fifth frame, a same-time arrival,
		// time going backwards, a partial drain, then an underrun.
		@(negedge clk);
		for (int i = 0; i < 5; i++)
			queue_pkt(0, 32'(i), TIME_W'(100 + i));
		queue_pkt(0, 32'd5, 48'd104);
		queue_pkt(0, 32'd6, 48'd50);
		queue_pkt(0, 32'd7, 48'd224);
		queue_pkt(0, 32'd8, 48'd624);
		// start at the last representable time, then wrap back to zero
		for (int i = 0; i < 5; i++)
			queue_pkt(FLOWS - 1, '1, '1);
		queue_pkt(FLOWS - 1, '0, '0);

		// Period 1 written with junk in the upper bits; start and clamp at one frame.
		wait_idle();
		set_regs(16'hFC01, 16'd1, 16'd1);
		@(negedge clk);
		queue_pkt(2, 32'h1234_5678, 48'd0);
		queue_pkt(2, 32'h0000_0001, 48'd0);
		// drain of exactly 2^17 frames must still stop the flow
		queue_pkt(2, 32'h8000_0000, 48'd131072);
		queue_pkt(3, 32'h5A5A_5A5A, 48'd7);
		queue_pkt(3, 32'hA5A5_A5A5, 48'd9);

		run_phase(16'd40, 16'd3, 16'd8, 0, 0, 95);
		run_phase(16'd1000, 16'd1, 16'hFFFF, 80, 0, 95);
		// hold the sender until every pending event is back
		while (pkts_to_send.size() > 55)
			@(negedge clk);
		send_hold = 1'b1;
		while (in_valid || events_due.size() != 0)
			@(negedge clk);
		send_hold = 1'b0;

		// zero period behaves as one ms; the spare index must be ignored
		wait_idle();
		write_reg(REG_SPARE, 16'hFFFF);
		run_phase(16'd0, 16'd2, 16'd1, 0, 80, 95);
		run_phase(16'd7, 16'd4, 16'd20, 15, 15, 95);
		// stopped flows can no longer start; playing ones drain out
		run_phase(16'd1023, 16'hFFFF, 16'hFFFF, 0, 0, 50);

		// Zero min_buffer never starts a flow; pile frames on one stopped flow.
		wait_idle();
		for (int i = FLOWS - 1; i >= 0; i--) begin
			if (!flow_playing[i])
				bulk_flow = i;
		end
		write_reg(REG_MIN_BUFFER, 16'd0);
		@(negedge clk);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (BULK_PKTS)
			queue_pkt(bulk_flow, $urandom(), flow_clock[bulk_flow]);
		// the count is already past one, so a min_buffer of one must not start the flow
		wait_idle();
		write_reg(REG_MIN_BUFFER, 16'd1);
		@(negedge clk);
		repeat (3)
			queue_pkt(bulk_flow, $urandom(), flow_clock[bulk_flow]);

		run_phase(16'(FRAME_PERIOD_RST), MIN_BUFFER_RST, MAX_BUFFER_RST, 15, 15, 50);

		wait_idle();
		if (errors == 0 && events_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
